// File: rtl/stt_pkg.sv
// Package for the source text tokenizer: scan modes, token kinds,
// controller states and the command and status structs.
// Depends on nothing.
package stt_pkg;

   localparam int MaxTokenLenDefault = 32;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_WORD  = 4'd1,
      MODE_INT   = 4'd2,
      MODE_STR   = 4'd3,
      MODE_ESC   = 4'd4,
      MODE_BANG  = 4'd5,
      MODE_EQ    = 4'd6,
      MODE_MINUS = 4'd7,
      MODE_ERROR = 4'd8
   } mode_type;

   localparam logic [4:0] KIND_WORD    = 5'd0;
   localparam logic [4:0] KIND_INT     = 5'd1;
   localparam logic [4:0] KIND_STRING  = 5'd2;
   localparam logic [4:0] KIND_BOOL    = 5'd3;
   localparam logic [4:0] KIND_LET     = 5'd4;
   localparam logic [4:0] KIND_IF      = 5'd5;
   localparam logic [4:0] KIND_ELSE    = 5'd6;
   localparam logic [4:0] KIND_WHILE   = 5'd7;
   localparam logic [4:0] KIND_I64     = 5'd8;
   localparam logic [4:0] KIND_STR     = 5'd9;
   localparam logic [4:0] KIND_BOOLT   = 5'd10;
   localparam logic [4:0] KIND_LPAREN  = 5'd11;
   localparam logic [4:0] KIND_RPAREN  = 5'd12;
   localparam logic [4:0] KIND_LBRACE  = 5'd13;
   localparam logic [4:0] KIND_RBRACE  = 5'd14;
   localparam logic [4:0] KIND_COMMA   = 5'd15;
   localparam logic [4:0] KIND_SEMI    = 5'd16;
   localparam logic [4:0] KIND_NE      = 5'd17;
   localparam logic [4:0] KIND_EQEQ    = 5'd18;
   localparam logic [4:0] KIND_ASSIGN  = 5'd19;
   localparam logic [4:0] KIND_PLUS    = 5'd20;
   localparam logic [4:0] KIND_ARROW   = 5'd21;
   localparam logic [4:0] KIND_MINUS   = 5'd22;
   localparam logic [4:0] KIND_STAR    = 5'd23;
   localparam logic [4:0] KIND_SLASH   = 5'd24;
   localparam logic [4:0] KIND_BADCHAR = 5'd25;
   localparam logic [4:0] KIND_BADESC  = 5'd26;
   localparam logic [4:0] KIND_END     = 5'd27;

   // Controller states.
   typedef enum logic [2:0] {
      ST_ACCEPT,   // waiting for an input transaction
      ST_SINGLE,   // one single result pending before the char step
      ST_DRAIN,    // streaming the buffered text
      ST_POST,     // apply the byte action after the results
      ST_END       // end result
   } state_type;

   // What the datapath should do with the accepted byte.
   typedef enum logic [2:0] {
      ACT_NONE,    // nothing more
      ACT_IDLE,    // scan the byte as in idle mode
      ACT_APPEND,  // append raw byte
      ACT_APPN,    // append a newline
      ACT_APPT     // append a tab
   } act_type;

   // Status from datapath to controller about the current transaction.
   typedef struct packed {
      logic       drain;       // buffered text must be streamed
      logic [4:0] drain_kind;
      logic       single;      // one single result before the byte action
      logic [4:0] single_kind;
      logic [7:0] single_char;
      logic       single_has;
      act_type    act;
      logic       is_end;
   } plan_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic take;         // capture a new item and its plan
      logic drain_step;   // a text result was delivered
      logic finish;       // item done: apply mode and byte action
   } cmd_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

// File: rtl/stt_req_if.sv
// Channel interfaces for the tokenizer: input bytes and result tokens.
// Depends on nothing.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_end;
   modport source (output valid, output ch, output is_end, input ready);
   modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface stt_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] kind;
   logic [7:0] value_char;
   logic       has_char;
   logic       last;
   logic       truncated;
   modport source (output valid, output kind, output value_char, output has_char,
                   output last, output truncated, input ready);
   modport sink (input valid, input kind, input value_char, input has_char,
                 input last, input truncated, output ready);
endinterface

// File: rtl/stt_ctrl.sv
// Controller for the tokenizer: sequences the results of one item.
// Depends on stt_pkg.
module stt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  stt_pkg::plan_type plan,
   input  logic              drain_last,
   input  logic              post_single,
   input  logic              out_free,
   output logic              out_load,
   output logic [2:0]        out_sel,
   output stt_pkg::cmd_type  cmd
);

   stt_pkg::state_type state_ff, state_in;

   // Next state. A finishing byte whose idle scan gives a result goes on to
   // deliver that result as a single.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stt_pkg::ST_ACCEPT: begin
            if (in_valid) begin
               if (plan.drain) state_in = stt_pkg::ST_DRAIN;
               else if (plan.single) state_in = stt_pkg::ST_SINGLE;
               else if (plan.is_end) state_in = stt_pkg::ST_END;
               else if (post_single) state_in = stt_pkg::ST_SINGLE;
            end
         end
         stt_pkg::ST_SINGLE: begin
            if (out_free) state_in = plan.is_end ? stt_pkg::ST_END : stt_pkg::ST_POST;
         end
         stt_pkg::ST_DRAIN: begin
            if (out_free && drain_last) begin
               if (plan.single) state_in = stt_pkg::ST_SINGLE;
               else if (plan.is_end) state_in = stt_pkg::ST_END;
               else state_in = stt_pkg::ST_POST;
            end
         end
         stt_pkg::ST_POST: state_in = post_single ? stt_pkg::ST_SINGLE : stt_pkg::ST_ACCEPT;
         stt_pkg::ST_END: begin
            if (out_free) state_in = stt_pkg::ST_ACCEPT;
         end
         default: state_in = stt_pkg::ST_ACCEPT;
      endcase
   end

   // Outputs. A plain byte with no result finishes in the accept cycle.
   always_comb begin
      in_ready = 1'b0;
      out_load = 1'b0;
      out_sel  = 3'd0;
      cmd      = '0;
      unique case (state_ff)
         stt_pkg::ST_ACCEPT: begin
            in_ready = 1'b1;
            cmd.take = in_valid;
            cmd.finish = in_valid && !plan.drain && !plan.single && !plan.is_end;
         end
         stt_pkg::ST_SINGLE: begin
            out_load = out_free;
            out_sel  = 3'd1;
         end
         stt_pkg::ST_DRAIN: begin
            out_load = out_free;
            out_sel  = 3'd2;
            cmd.drain_step = out_free;
         end
         stt_pkg::ST_POST: cmd.finish = 1'b1;
         stt_pkg::ST_END: begin
            out_load = out_free;
            out_sel  = 3'd3;
            cmd.finish = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= stt_pkg::ST_ACCEPT;
      else state_ff <= state_in;
   end

endmodule

// File: rtl/stt_dpath.sv
// Datapath for the tokenizer: scan mode, text buffer, keyword check,
// byte planning and the result register.
// Depends on stt_pkg.
module stt_dpath #(
   parameter int MAX_TOKEN_LEN = stt_pkg::MaxTokenLenDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        in_ch,
   input  logic              in_is_end,
   output stt_pkg::plan_type plan,
   output logic              drain_last,
   output logic              post_single,
   input  stt_pkg::cmd_type  cmd,
   input  logic              out_load,
   input  logic [2:0]        out_sel,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        rsp_kind,
   output logic [7:0]        rsp_value_char,
   output logic              rsp_has_char,
   output logic              rsp_last,
   output logic              rsp_truncated
);

   localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
   localparam int AW = $clog2(MAX_TOKEN_LEN);

   stt_pkg::mode_type mode_ff, mode_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        buf_ff [MAX_TOKEN_LEN];
   logic [LW-1:0]     rd_ff, rd_in;
   stt_pkg::plan_type plan_ff;
   logic [7:0]        ch_ff;
   logic              vld_ff;
   logic [4:0]        kind_ff;
   logic [7:0]        char_ff;
   logic              has_ff, last_ff, trunc_ff;

   stt_pkg::plan_type pl;
   logic [4:0]        word_kind;
   logic              word_valued;
   logic [7:0]        word_char;
   logic              word_hit;

   function automatic logic text_is(input logic [7:0] b [MAX_TOKEN_LEN],
                                    input logic [LW-1:0] n, input logic ov,
                                    input logic [39:0] s, input int sl);
      logic ok;
      ok = !ov && (n == LW'(sl));
      for (int i = 0; i < 5; i++) begin
         if (i < sl && i < MAX_TOKEN_LEN) ok = ok && (b[i] == s[8*(sl-1-i) +: 8]);
      end
      return ok;
   endfunction

   // Keyword, bool and word classification of the buffered text.
   always_comb begin
      word_hit = 1'b1;
      word_valued = 1'b0;
      word_char = 8'h00;
      word_kind = stt_pkg::KIND_WORD;
      priority if (text_is(buf_ff, len_ff, ovf_ff, 40'h74727565, 4)) begin
         word_kind = stt_pkg::KIND_BOOL; word_valued = 1'b1; word_char = 8'h31;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h66616c7365, 5)) begin
         word_kind = stt_pkg::KIND_BOOL; word_valued = 1'b1; word_char = 8'h30;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h6c6574, 3)) begin
         word_kind = stt_pkg::KIND_LET;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h6966, 2)) begin
         word_kind = stt_pkg::KIND_IF;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h656c7365, 4)) begin
         word_kind = stt_pkg::KIND_ELSE;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h7768696c65, 5)) begin
         word_kind = stt_pkg::KIND_WHILE;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h693634, 3)) begin
         word_kind = stt_pkg::KIND_I64;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h737472, 3)) begin
         word_kind = stt_pkg::KIND_STR;
      end else if (text_is(buf_ff, len_ff, ovf_ff, 40'h626f6f6c, 4)) begin
         word_kind = stt_pkg::KIND_BOOLT;
      end else begin
         word_hit = 1'b0;
      end
   end

   // Plan for the byte on the input. A result from the idle scan of the byte
   // is found only when the item finishes and is then sent as an extra single.
   always_comb begin
      pl = '0;
      pl.is_end = in_is_end;
      pl.single_char = 8'h00;
      pl.act = stt_pkg::ACT_NONE;
      if (in_is_end) begin
         unique case (mode_ff)
            stt_pkg::MODE_WORD: begin
               if (word_hit) begin
                  pl.single = 1'b1; pl.single_kind = word_kind;
                  pl.single_char = word_char; pl.single_has = word_valued;
               end else begin
                  pl.drain = 1'b1; pl.drain_kind = stt_pkg::KIND_WORD;
               end
            end
            stt_pkg::MODE_INT: begin pl.drain = 1'b1; pl.drain_kind = stt_pkg::KIND_INT; end
            stt_pkg::MODE_STR: begin pl.drain = 1'b1; pl.drain_kind = stt_pkg::KIND_STRING; end
            stt_pkg::MODE_ESC: begin pl.single = 1'b1; pl.single_kind = stt_pkg::KIND_BADESC; end
            stt_pkg::MODE_EQ: begin pl.single = 1'b1; pl.single_kind = stt_pkg::KIND_ASSIGN; end
            stt_pkg::MODE_MINUS: begin pl.single = 1'b1; pl.single_kind = stt_pkg::KIND_MINUS; end
            default: ;
         endcase
      end else begin
         unique case (mode_ff)
            stt_pkg::MODE_WORD: begin
               if (stt_pkg::is_letter(in_ch) || stt_pkg::is_digit(in_ch)) begin
                  pl.act = stt_pkg::ACT_APPEND;
               end else begin
                  pl.act = stt_pkg::ACT_IDLE;
                  if (word_hit) begin
                     pl.single = 1'b1; pl.single_kind = word_kind;
                     pl.single_char = word_char; pl.single_has = word_valued;
                  end else begin
                     pl.drain = 1'b1; pl.drain_kind = stt_pkg::KIND_WORD;
                  end
               end
            end
            stt_pkg::MODE_INT: begin
               if (stt_pkg::is_digit(in_ch)) pl.act = stt_pkg::ACT_APPEND;
               else begin
                  pl.act = stt_pkg::ACT_IDLE;
                  pl.drain = 1'b1; pl.drain_kind = stt_pkg::KIND_INT;
               end
            end
            stt_pkg::MODE_STR: begin
               if (in_ch == 8'h22) begin
                  pl.drain = 1'b1; pl.drain_kind = stt_pkg::KIND_STRING;
               end else if (in_ch != 8'h5c) begin
                  pl.act = stt_pkg::ACT_APPEND;
               end
            end
            stt_pkg::MODE_ESC: begin
               if (in_ch == 8'h6e) pl.act = stt_pkg::ACT_APPN;
               else if (in_ch == 8'h74) pl.act = stt_pkg::ACT_APPT;
               else begin
                  pl.single = 1'b1; pl.single_kind = stt_pkg::KIND_BADESC;
                  pl.single_char = in_ch; pl.single_has = 1'b1;
               end
            end
            stt_pkg::MODE_BANG: begin
               if (in_ch == 8'h3d) begin
                  pl.single = 1'b1; pl.single_kind = stt_pkg::KIND_NE;
               end else pl.act = stt_pkg::ACT_IDLE;
            end
            stt_pkg::MODE_EQ: begin
               pl.single = 1'b1;
               if (in_ch == 8'h3d) pl.single_kind = stt_pkg::KIND_EQEQ;
               else begin
                  pl.single_kind = stt_pkg::KIND_ASSIGN; pl.act = stt_pkg::ACT_IDLE;
               end
            end
            stt_pkg::MODE_MINUS: begin
               pl.single = 1'b1;
               if (in_ch == 8'h3e) pl.single_kind = stt_pkg::KIND_ARROW;
               else begin
                  pl.single_kind = stt_pkg::KIND_MINUS; pl.act = stt_pkg::ACT_IDLE;
               end
            end
            stt_pkg::MODE_IDLE: pl.act = stt_pkg::ACT_IDLE;
            default: ;
         endcase
      end
   end

   // The plan seen by the controller is the live one while accepting and the
   // captured one afterwards. A trailing idle-scan result is turned into a pending
   // single when the item finishes, in ST_ACCEPT or ST_POST; see post logic below.
   logic post_pending_ff, post_pending_in;
   always_comb begin
      plan = cmd.take ? pl : plan_ff;
      if (!cmd.take && post_pending_ff) begin
         plan.single = 1'b1;
         plan.drain = 1'b0;
      end
   end

   assign drain_last = (len_ff == '0) || (rd_ff + LW'(1) >= len_ff);

   // Byte action and mode update applied when the item finishes, including
   // the idle scan which may itself produce a single result.
   logic [7:0]        fch;
   stt_pkg::act_type  fact;
   logic              f_idle_single;
   logic [4:0]        f_idle_kind;
   stt_pkg::mode_type f_idle_mode;
   logic              app_en;
   logic [7:0]        app_ch;
   logic              clr;

   // Idle scan of the captured byte.
   always_comb begin
      f_idle_mode = stt_pkg::MODE_IDLE;
      f_idle_single = 1'b1;
      f_idle_kind = stt_pkg::KIND_BADCHAR;
      if (stt_pkg::is_letter(fch)) begin
         f_idle_mode = stt_pkg::MODE_WORD; f_idle_single = 1'b0;
      end else if (stt_pkg::is_digit(fch)) begin
         f_idle_mode = stt_pkg::MODE_INT; f_idle_single = 1'b0;
      end else begin
         unique case (fch)
            8'h22: begin f_idle_mode = stt_pkg::MODE_STR; f_idle_single = 1'b0; end
            8'h21: begin f_idle_mode = stt_pkg::MODE_BANG; f_idle_single = 1'b0; end
            8'h3d: begin f_idle_mode = stt_pkg::MODE_EQ; f_idle_single = 1'b0; end
            8'h2d: begin f_idle_mode = stt_pkg::MODE_MINUS; f_idle_single = 1'b0; end
            8'h28: f_idle_kind = stt_pkg::KIND_LPAREN;
            8'h29: f_idle_kind = stt_pkg::KIND_RPAREN;
            8'h7b: f_idle_kind = stt_pkg::KIND_LBRACE;
            8'h7d: f_idle_kind = stt_pkg::KIND_RBRACE;
            8'h2c: f_idle_kind = stt_pkg::KIND_COMMA;
            8'h3b: f_idle_kind = stt_pkg::KIND_SEMI;
            8'h2b: f_idle_kind = stt_pkg::KIND_PLUS;
            8'h2a: f_idle_kind = stt_pkg::KIND_STAR;
            8'h2f: f_idle_kind = stt_pkg::KIND_SLASH;
            8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: f_idle_single = 1'b0;
            default: f_idle_mode = stt_pkg::MODE_ERROR;
         endcase
      end
   end

   // Finish: new mode, buffer append or clear, and a possible idle result.
   logic              fin_single;
   always_comb begin
      fch = cmd.take ? in_ch : ch_ff;
      fact = cmd.take ? pl.act : plan_ff.act;
      mode_in = mode_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      rd_in = rd_ff;
      app_en = 1'b0;
      app_ch = fch;
      clr = 1'b0;
      fin_single = 1'b0;
      post_pending_in = post_pending_ff;
      if (cmd.take) rd_in = '0;
      if (cmd.drain_step) rd_in = rd_ff + LW'(1);
      if (cmd.finish && !post_pending_ff) begin
         unique case (fact)
            stt_pkg::ACT_APPEND, stt_pkg::ACT_APPN, stt_pkg::ACT_APPT: begin
               app_en = 1'b1;
               if (fact == stt_pkg::ACT_APPN) app_ch = 8'h0a;
               if (fact == stt_pkg::ACT_APPT) app_ch = 8'h09;
               if (mode_ff == stt_pkg::MODE_ESC) mode_in = stt_pkg::MODE_STR;
            end
            stt_pkg::ACT_IDLE: begin
               clr = 1'b1;
               mode_in = f_idle_mode;
               if (f_idle_mode == stt_pkg::MODE_WORD || f_idle_mode == stt_pkg::MODE_INT)
                  app_en = 1'b1;
               fin_single = f_idle_single;
            end
            stt_pkg::ACT_NONE: begin
               clr = 1'b1;
               if (plan_ff.is_end && !cmd.take) mode_in = stt_pkg::MODE_IDLE;
               else begin
                  unique case (mode_ff)
                     stt_pkg::MODE_STR: mode_in = (fch == 8'h22) ? stt_pkg::MODE_IDLE
                                                                 : stt_pkg::MODE_ESC;
                     stt_pkg::MODE_ESC: mode_in = stt_pkg::MODE_ERROR;
                     stt_pkg::MODE_BANG, stt_pkg::MODE_EQ, stt_pkg::MODE_MINUS:
                        mode_in = stt_pkg::MODE_IDLE;
                     default: ;
                  endcase
                  if (mode_ff == stt_pkg::MODE_STR && fch == 8'h5c) clr = 1'b0;
               end
            end
            default: ;
         endcase
         post_pending_in = fin_single;
      end else if (cmd.finish && post_pending_ff) begin
         post_pending_in = 1'b0;
      end
      if (clr) begin
         len_in = '0;
         ovf_in = 1'b0;
      end
      if (app_en) begin
         if (len_in < LW'(MAX_TOKEN_LEN)) len_in = len_in + LW'(1);
         else ovf_in = 1'b1;
      end
   end

   assign post_single = fin_single;

   // Captured plan, with the idle-scan result folded in when one appears.
   // Punctuation carries no character; an unknown byte carries itself.
   stt_pkg::plan_type plan_nx;
   always_comb begin
      plan_nx = cmd.take ? pl : plan_ff;
      if (fin_single) begin
         plan_nx.single_kind = f_idle_kind;
         plan_nx.single_has = (f_idle_kind == stt_pkg::KIND_BADCHAR);
         plan_nx.single_char = plan_nx.single_has ? fch : 8'h00;
         plan_nx.is_end = 1'b0;
         plan_nx.act = stt_pkg::ACT_NONE;
      end
   end

   // Result register with its one-entry hold.
   assign out_free = !vld_ff || rsp_ready;
   assign rsp_valid = vld_ff;
   assign rsp_kind = kind_ff;
   assign rsp_value_char = char_ff;
   assign rsp_has_char = has_ff;
   assign rsp_last = last_ff;
   assign rsp_truncated = trunc_ff;

   logic [LW-1:0] wr_idx;
   assign wr_idx = clr ? '0 : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stt_pkg::MODE_IDLE;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         vld_ff <= 1'b0;
         post_pending_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         post_pending_ff <= post_pending_in;
         if (out_load) vld_ff <= 1'b1;
         else if (rsp_ready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      plan_ff <= plan_nx;
      if (cmd.take) ch_ff <= in_ch;
      if (app_en && wr_idx < LW'(MAX_TOKEN_LEN)) buf_ff[wr_idx[AW-1:0]] <= app_ch;
      if (out_load) begin
         unique case (out_sel)
            3'd1: begin
               kind_ff <= plan.single_kind; char_ff <= plan.single_char;
               has_ff <= plan.single_has; last_ff <= 1'b1; trunc_ff <= 1'b0;
            end
            3'd2: begin
               kind_ff <= plan.drain_kind;
               char_ff <= (len_ff == '0) ? 8'h00 : buf_ff[rd_ff[AW-1:0]];
               has_ff <= (len_ff != '0);
               last_ff <= drain_last;
               trunc_ff <= ovf_ff;
            end
            default: begin
               kind_ff <= stt_pkg::KIND_END; char_ff <= 8'h00;
               has_ff <= 1'b0; last_ff <= 1'b1; trunc_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// File: rtl/source_text_tokenizer.sv
// Source text tokenizer: one byte per transaction in, tokens out.
// A byte with no result finishes in its accept step; one with a single result
// goes through take, result and apply steps, each further single adding a
// result and an apply step. Buffered text streams one character per cycle while
// output is free; end of input sends its end result in place of the apply step.
// Synchronous active-high reset returns to idle mode with an empty buffer.
module source_text_tokenizer #(
   parameter int MAX_TOKEN_LEN = stt_pkg::MaxTokenLenDefault
) (
   input logic     clock,
   input logic     reset,
   stt_req_if.sink req,
   stt_rsp_if.source rsp
);

   stt_pkg::plan_type plan;
   stt_pkg::cmd_type  cmd;
   logic              drain_last, post_single, out_free, out_load;
   logic [2:0]        out_sel;

   // Sequencing of results for each item.
   stt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .plan(plan), .drain_last(drain_last), .post_single(post_single),
      .out_free(out_free), .out_load(out_load), .out_sel(out_sel), .cmd(cmd)
   );

   // Scanning state and result register.
   stt_dpath #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_dpath (
      .clock(clock), .reset(reset), .in_ch(req.ch), .in_is_end(req.is_end),
      .plan(plan), .drain_last(drain_last), .post_single(post_single), .cmd(cmd),
      .out_load(out_load), .out_sel(out_sel), .out_free(out_free),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.kind),
      .rsp_value_char(rsp.value_char), .rsp_has_char(rsp.has_char),
      .rsp_last(rsp.last), .rsp_truncated(rsp.truncated)
   );

endmodule
